/* design/sirp_pkg.sv */
package sirp_pkg;

    localparam logic [7:0] REPLY_TYPE_INFO = 8'h49;
    localparam logic [2:0] HEADER_SKIP     = 3'd4;
    localparam logic [1:0] LAST_STRING     = 2'd3;

    typedef enum logic [3:0] {
        PH_HEADER   = 4'd0,
        PH_PROTOCOL = 4'd1,
        PH_STRINGS  = 4'd2,
        PH_APP_LO   = 4'd3,
        PH_APP_HI   = 4'd4,
        PH_PLAYERS  = 4'd5,
        PH_LIMIT    = 4'd6,
        PH_BOTS     = 4'd7,
        PH_DONE     = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_TYPE  = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [7:0]         protocol_version;
        logic signed [15:0] application_id;
        logic [7:0]         player_count;
        logic [7:0]         player_limit;
        logic [7:0]         bot_count;
    } t_result;

endpackage

/* design/sirp_in_if.sv */
interface sirp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_packet;

    modport source(output valid, output data_byte, output end_of_packet, input ready);
    modport sink(input valid, input data_byte, input end_of_packet, output ready);
endinterface

/* design/sirp_out_if.sv */
interface sirp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [7:0]         protocol_version;
    logic signed [15:0] application_id;
    logic [7:0]         player_count;
    logic [7:0]         player_limit;
    logic [7:0]         bot_count;

    modport source(
        output valid, output status, output protocol_version, output application_id,
        output player_count, output player_limit, output bot_count, input ready
    );
    modport sink(
        input valid, input status, input protocol_version, input application_id,
        input player_count, input player_limit, input bot_count, output ready
    );
endinterface

/* design/sirp_parser.sv */
module sirp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_eop,
    output sirp_pkg::t_result o_result
);
    import sirp_pkg::*;

    t_phase             r_phase, c_phase, n_phase;
    logic [2:0]         r_hpos, c_hpos, n_hpos;
    logic [1:0]         r_strings, c_strings, n_strings;
    logic               r_mismatch, c_mismatch, n_mismatch;
    logic [7:0]         r_protocol, n_protocol;
    logic [15:0]        r_app_id, n_app_id;
    logic [7:0]         r_players, n_players;
    logic [7:0]         r_limit, n_limit;
    logic [7:0]         r_bots, n_bots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hpos     <= '0;
            r_strings  <= '0;
            r_mismatch <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_hpos     <= n_hpos;
            r_strings  <= n_strings;
            r_mismatch <= n_mismatch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_protocol <= n_protocol;
            r_app_id   <= n_app_id;
            r_players  <= n_players;
            r_limit    <= n_limit;
            r_bots     <= n_bots;
        end
    end

    always_comb begin
        c_phase    = r_phase;
        c_hpos     = r_hpos;
        c_strings  = r_strings;
        c_mismatch = r_mismatch;
        n_protocol = r_protocol;
        n_app_id   = r_app_id;
        n_players  = r_players;
        n_limit    = r_limit;
        n_bots     = r_bots;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_hpos < HEADER_SKIP) begin
                    c_hpos = r_hpos + 3'd1;
                end else if (i_byte != REPLY_TYPE_INFO) begin
                    c_mismatch = 1'b1;
                    c_phase    = PH_DONE;
                end else begin
                    c_phase = PH_PROTOCOL;
                end
            end
            PH_PROTOCOL: begin
                n_protocol = i_byte;
                c_phase    = PH_STRINGS;
            end
            PH_STRINGS: begin
                if (i_byte == 8'd0) begin
                    if (r_strings == LAST_STRING) begin
                        c_phase = PH_APP_LO;
                    end else begin
                        c_strings = r_strings + 2'd1;
                    end
                end
            end
            PH_APP_LO: begin
                n_app_id[7:0] = i_byte;
                c_phase       = PH_APP_HI;
            end
            PH_APP_HI: begin
                n_app_id[15:8] = i_byte;
                c_phase        = PH_PLAYERS;
            end
            PH_PLAYERS: begin
                n_players = i_byte;
                c_phase   = PH_LIMIT;
            end
            PH_LIMIT: begin
                n_limit = i_byte;
                c_phase = PH_BOTS;
            end
            PH_BOTS: begin
                n_bots  = i_byte;
                c_phase = PH_DONE;
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        o_result = '0;
        if (c_mismatch) begin
            o_result.status = ST_BAD_TYPE;
        end else if (c_phase == PH_DONE) begin
            o_result.status           = ST_OK;
            o_result.protocol_version = n_protocol;
            o_result.application_id   = n_app_id;
            o_result.player_count     = n_players;
            o_result.player_limit     = n_limit;
            o_result.bot_count        = n_bots;
        end else begin
            o_result.status = ST_TRUNCATED;
        end

        // packet closes: back to the header phase for the next one
        if (i_eop) begin
            n_phase    = PH_HEADER;
            n_hpos     = '0;
            n_strings  = '0;
            n_mismatch = 1'b0;
        end else begin
            n_phase    = c_phase;
            n_hpos     = c_hpos;
            n_strings  = c_strings;
            n_mismatch = c_mismatch;
        end
    end
endmodule

/* design/sirp_out_stage.sv */
module sirp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sirp_pkg::t_result i_result,
    output logic              o_advance,
    sirp_out_if.source        o_out
);
    import sirp_pkg::*;

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_advance = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (o_advance) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.status           = r_result.status;
    assign o_out.protocol_version = r_result.protocol_version;
    assign o_out.application_id   = r_result.application_id;
    assign o_out.player_count     = r_result.player_count;
    assign o_out.player_limit     = r_result.player_limit;
    assign o_out.bot_count        = r_result.bot_count;
endmodule

/* design/server_info_reply_parser.sv */
// Server-info reply parser: takes one datagram byte per transaction, with
// end_of_packet on the final byte, and returns one transaction per datagram
// carrying the status and the decoded protocol, application id and counts
// (all fields zero unless the status is ok). A byte is taken every cycle
// while the result side keeps up; each byte is held in an input register and
// the parse step between it and the result register is combinational, so
// a datagram's result is loaded into the result register from its final byte.
module server_info_reply_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sirp_in_if.sink   i_in,
    sirp_out_if.source o_out
);
    import sirp_pkg::*;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_byte;
    logic       r_eop;
    logic       advance;
    logic       step;
    t_result    result;

    assign i_in.ready = !r_in_valid || advance;
    assign step       = r_in_valid && advance;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_in.valid && i_in.ready) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.data_byte;
            r_eop  <= i_in.end_of_packet;
        end
    end

    sirp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_byte),
        .i_eop    (r_eop),
        .o_result (result)
    );

    sirp_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (r_in_valid && r_eop),
        .i_result  (result),
        .o_advance (advance),
        .o_out     (o_out)
    );
endmodule
